// ===== design/ffba_pkg.sv =====
`timescale 1ns / 1ps
package ffba_pkg;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_RD,
		ST_A_CMP,
		ST_F_RD,
		ST_F_CMP,
		ST_P_RD,
		ST_P_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS_WR
	} state_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NOFIT    = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam int FIELD_BITS = 16;
	localparam logic [FIELD_BITS-1:0] TOTAL_RESET = 16'hFFFF;

endpackage

// ===== design/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// First-fit allocator keeping a free table ordered by base and a used table in
// allocation order, each held in a synchronous memory of (base, length) entries.
// A request word is taken when start is high and busy is low; kind selects an
// allocate of req_size bytes or a free of the block at block_addr.
// One result word follows each request: done is high for exactly one cycle with
// status and alloc_addr valid, and the receiver must take it in that cycle.
// Each memory has one registered read port, so each entry visited takes a
// read state and a compare state, and every move is a read then a write. An
// allocate scans the free table and, on an exact fit, shifts it down over the
// taken entry; a free scans the used table, searches the free table in order,
// shifts it up to insert the freed block, and shifts the used table down.
// The total_size register is written through the cfg channel while the block
// is idle; a write re-initialises both tables through the init state.
// After reset the block writes the first free entry in its init state and then
// accepts requests with total_size equal to 65535.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = 16,
	parameter int ADDR_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [15:0] req_size,
	input  logic [15:0] block_addr,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] alloc_addr,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int AW = ADDR_BITS;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int DW = 2 * AW;

	ffba_pkg::state_t state_q, state_nxt;

	logic [CW-1:0] fc_q, uc_q, i_q, j_q;
	logic [IW-1:0] k_q, end_q;
	logic          up_q, tbl_q;
	logic [AW-1:0] req_q, b_q, l_q, addr_q;
	logic [15:0]   tot_q;
	logic          done_q;
	logic [1:0]    status_q;
	logic [15:0]   alloc_addr_q;

	logic          f_we, u_we;
	logic [IW-1:0] f_waddr, u_waddr, f_raddr, u_raddr;
	logic [DW-1:0] f_wdata, u_wdata, f_rdata, u_rdata;

	logic          fin;
	logic [1:0]    fin_st;
	logic [AW-1:0] fin_addr;

	logic [AW-1:0] f_base, f_len, u_base, u_len;
	logic          fit, match, ge, uc_full, fc_full, at_end;
	logic [IW-1:0] src;

	assign f_base  = f_rdata[DW-1:AW];
	assign f_len   = f_rdata[AW-1:0];
	assign u_base  = u_rdata[DW-1:AW];
	assign u_len   = u_rdata[AW-1:0];
	assign fit     = (req_q <= f_len);
	assign match   = (u_base == b_q);
	assign ge      = (f_base >= b_q);
	assign uc_full = (uc_q == CW'(MAX_BLOCKS));
	assign fc_full = (fc_q == CW'(MAX_BLOCKS));
	assign at_end  = (k_q == end_q);
	assign src     = up_q ? (k_q - IW'(1)) : (k_q + IW'(1));

	assign busy      = (state_q != ffba_pkg::ST_IDLE);
	assign cfg_ready = (state_q == ffba_pkg::ST_IDLE) && !start;
	assign done       = done_q;
	assign status     = status_q;
	assign alloc_addr = alloc_addr_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ffba_pkg::ST_INIT: state_nxt = ffba_pkg::ST_IDLE;
			ffba_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = (kind == ffba_pkg::KIND_FREE) ? ffba_pkg::ST_F_RD
						: ffba_pkg::ST_A_RD;
				end else if (cfg_valid) begin
					state_nxt = ffba_pkg::ST_INIT;
				end
			end
			ffba_pkg::ST_A_RD: begin
				state_nxt = (i_q == fc_q) ? ffba_pkg::ST_IDLE : ffba_pkg::ST_A_CMP;
			end
			ffba_pkg::ST_A_CMP: begin
				if (!fit) begin
					state_nxt = ffba_pkg::ST_A_RD;
				end else if (uc_full || (f_len != req_q)) begin
					state_nxt = ffba_pkg::ST_IDLE;
				end else begin
					state_nxt = ffba_pkg::ST_SH_RD;
				end
			end
			ffba_pkg::ST_F_RD: begin
				state_nxt = (i_q == uc_q) ? ffba_pkg::ST_IDLE : ffba_pkg::ST_F_CMP;
			end
			ffba_pkg::ST_F_CMP: begin
				if (!match) begin
					state_nxt = ffba_pkg::ST_F_RD;
				end else begin
					state_nxt = fc_full ? ffba_pkg::ST_IDLE : ffba_pkg::ST_P_RD;
				end
			end
			ffba_pkg::ST_P_RD: begin
				state_nxt = (j_q == fc_q) ? ffba_pkg::ST_SH_RD : ffba_pkg::ST_P_CMP;
			end
			ffba_pkg::ST_P_CMP: begin
				state_nxt = ge ? ffba_pkg::ST_SH_RD : ffba_pkg::ST_P_RD;
			end
			ffba_pkg::ST_SH_RD: begin
				if (!at_end) begin
					state_nxt = ffba_pkg::ST_SH_WR;
				end else begin
					state_nxt = up_q ? ffba_pkg::ST_INS_WR : ffba_pkg::ST_IDLE;
				end
			end
			ffba_pkg::ST_SH_WR:  state_nxt = ffba_pkg::ST_SH_RD;
			ffba_pkg::ST_INS_WR: state_nxt = ffba_pkg::ST_SH_RD;
			default:             state_nxt = ffba_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		fin      = 1'b0;
		fin_st   = ffba_pkg::STAT_OK;
		fin_addr = addr_q;
		f_we     = 1'b0;
		f_waddr  = k_q;
		f_wdata  = f_rdata;
		f_raddr  = src;
		u_we     = 1'b0;
		u_waddr  = k_q;
		u_wdata  = u_rdata;
		u_raddr  = src;
		unique case (state_q)
			ffba_pkg::ST_INIT: begin
				f_we    = 1'b1;
				f_waddr = '0;
				f_wdata = {AW'(0), AW'(32'(tot_q))};
			end
			ffba_pkg::ST_A_RD: begin
				f_raddr = i_q[IW-1:0];
				if (i_q == fc_q) begin
					fin    = 1'b1;
					fin_st = ffba_pkg::STAT_NOFIT;
				end
			end
			ffba_pkg::ST_A_CMP: begin
				if (fit) begin
					if (uc_full) begin
						fin    = 1'b1;
						fin_st = ffba_pkg::STAT_FULL;
					end else begin
						u_we    = 1'b1;
						u_waddr = uc_q[IW-1:0];
						if (f_len != req_q) begin
							fin      = 1'b1;
							fin_addr = f_base + (f_len - req_q);
							f_we     = 1'b1;
							f_waddr  = i_q[IW-1:0];
							f_wdata  = {f_base, f_len - req_q};
							u_wdata  = {f_base + (f_len - req_q), req_q};
						end else begin
							u_wdata = f_rdata;
						end
					end
				end
			end
			ffba_pkg::ST_F_RD: begin
				u_raddr = i_q[IW-1:0];
				if (i_q == uc_q) begin
					fin    = 1'b1;
					fin_st = ffba_pkg::STAT_NOTFOUND;
				end
			end
			ffba_pkg::ST_F_CMP: begin
				if (match && fc_full) begin
					fin    = 1'b1;
					fin_st = ffba_pkg::STAT_FULL;
				end
			end
			ffba_pkg::ST_P_RD: f_raddr = j_q[IW-1:0];
			ffba_pkg::ST_SH_RD: begin
				if (at_end && !up_q) begin
					fin = 1'b1;
				end
			end
			ffba_pkg::ST_SH_WR: begin
				f_we = !tbl_q;
				u_we = tbl_q;
			end
			ffba_pkg::ST_INS_WR: begin
				f_we    = 1'b1;
				f_wdata = {b_q, l_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ffba_pkg::ST_INIT;
			tot_q        <= ffba_pkg::TOTAL_RESET;
			fc_q         <= '0;
			uc_q         <= '0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			end_q        <= '0;
			up_q         <= 1'b0;
			tbl_q        <= 1'b0;
			req_q        <= '0;
			b_q          <= '0;
			l_q          <= '0;
			addr_q       <= '0;
			done_q       <= 1'b0;
			status_q     <= '0;
			alloc_addr_q <= '0;
		end else begin
			state_q <= state_nxt;
			done_q  <= fin;
			if (fin) begin
				status_q     <= fin_st;
				alloc_addr_q <= (fin_st == ffba_pkg::STAT_OK) ? 16'(32'(fin_addr)) : 16'd0;
			end
			unique case (state_q)
				ffba_pkg::ST_INIT: begin
					fc_q <= CW'(1);
					uc_q <= '0;
				end
				ffba_pkg::ST_IDLE: begin
					if (start) begin
						i_q    <= '0;
						j_q    <= '0;
						req_q  <= AW'(32'(req_size));
						b_q    <= AW'(32'(block_addr));
						addr_q <= '0;
					end else if (cfg_valid) begin
						tot_q <= cfg_data;
					end
				end
				ffba_pkg::ST_A_CMP: begin
					if (!fit) begin
						i_q <= i_q + CW'(1);
					end else if (!uc_full) begin
						uc_q <= uc_q + CW'(1);
						if (f_len != req_q) begin
							addr_q <= f_base + (f_len - req_q);
						end else begin
							addr_q <= f_base;
							k_q    <= i_q[IW-1:0];
							end_q  <= IW'(fc_q - CW'(1));
							fc_q   <= fc_q - CW'(1);
							up_q   <= 1'b0;
							tbl_q  <= 1'b0;
						end
					end
				end
				ffba_pkg::ST_F_CMP: begin
					if (!match) begin
						i_q <= i_q + CW'(1);
					end else begin
						l_q <= u_len;
					end
				end
				ffba_pkg::ST_P_RD: begin
					if (j_q == fc_q) begin
						k_q   <= fc_q[IW-1:0];
						end_q <= j_q[IW-1:0];
						up_q  <= 1'b1;
						tbl_q <= 1'b0;
					end
				end
				ffba_pkg::ST_P_CMP: begin
					if (ge) begin
						k_q   <= fc_q[IW-1:0];
						end_q <= j_q[IW-1:0];
						up_q  <= 1'b1;
						tbl_q <= 1'b0;
					end else begin
						j_q <= j_q + CW'(1);
					end
				end
				ffba_pkg::ST_SH_WR: k_q <= src;
				ffba_pkg::ST_INS_WR: begin
					fc_q  <= fc_q + CW'(1);
					k_q   <= i_q[IW-1:0];
					end_q <= IW'(uc_q - CW'(1));
					uc_q  <= uc_q - CW'(1);
					up_q  <= 1'b0;
					tbl_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	ffba_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(DW)) u_free_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	ffba_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(DW)) u_used_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.raddr (u_raddr),
		.rdata (u_rdata)
	);

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(fc_q <= CW'(MAX_BLOCKS)) && (uc_q <= CW'(MAX_BLOCKS)))
		else $error("block table count beyond its depth");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_cfg_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (state_q == ffba_pkg::ST_INIT))
		else $error("register write did not re-initialise the tables");

	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done_q)
		else $error("result produced in the cycle after a request was taken");

endmodule

// ===== design/ffba_ram.sv =====
`timescale 1ns / 1ps
module ffba_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
